>>> src/tbhu_pkg.sv
// Shared constants, handshake-side types and the color ramp table of the heat-map upscaler.
package tbhu_pkg;

    // Defaults of the top-level parameters
    localparam int SRC_WIDTH_DEF  = 32;
    localparam int SRC_HEIGHT_DEF = 24;
    localparam int DST_WIDTH_DEF  = 480;
    localparam int ROWS_DEF       = 13;

    // Fixed field widths and related constants
    localparam int LEVEL_W   = 8;
    localparam int COLOR_W   = 16;
    localparam int WADDR_W   = 10;
    localparam int PIX_W     = 9;
    localparam int PIX_MAX   = (1 << PIX_W) - 1;
    localparam int FRAC_W    = 8;
    localparam int FRAC_ONE  = 256;
    localparam int WEIGHT_W  = 2 * FRAC_W + 1;
    localparam int PROD_W    = LEVEL_W + 2 * FRAC_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ROUND_HALF = 32768;
    localparam int LEVEL_MAX = 255;

    // Color ramp segment starts
    localparam int unsigned RAMP_K1 = 85;
    localparam int unsigned RAMP_K2 = 150;
    localparam int unsigned RAMP_K3 = 210;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        logic [LEVEL_W-1:0] level;
    } wr_req_t;

    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } frac_t;

    localparam int RAMP_ENTRIES = 1 << LEVEL_W;
    localparam int RAMP_BITS    = RAMP_ENTRIES * COLOR_W;

    function automatic logic [RAMP_BITS-1:0] build_ramp();
        logic [RAMP_BITS-1:0] lut;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned t;
        int unsigned col;
        lut = '0;
        for (int unsigned i = 0; i < RAMP_ENTRIES; i++)
        begin
            if (i < RAMP_K1)
            begin
                r = 60 + (i * 140) / 84;
                g = 0;
                b = 40 + (i * 140) / 84;
            end
            else if (i < RAMP_K2)
            begin
                t = i - RAMP_K1;
                r = 200 + (t * 55) / 64;
                g = 0;
                b = 180 - (t * 180) / 64;
            end
            else if (i < RAMP_K3)
            begin
                t = i - RAMP_K2;
                r = 255;
                g = (t * 180) / 59;
                b = 0;
            end
            else
            begin
                t = i - RAMP_K3;
                r = 255;
                g = 180 + (t * 75) / 45;
                b = 0;
            end
            if (r > 255) r = 255;
            if (g > 255) g = 255;
            if (b > 255) b = 255;
            col = ((r & 32'hF8) << 8) | ((g & 32'hFC) << 3) | (b >> 3);
            lut[i*COLOR_W +: COLOR_W] = COLOR_W'(col);
        end
        return lut;
    endfunction

    localparam logic [RAMP_BITS-1:0] RAMP_LUT = build_ramp();

endpackage

>>> src/tbhu_cdiv.sv
// Division of an unsigned value by a fixed divisor through a reciprocal multiply.
module tbhu_cdiv #(
    parameter int NUM_W   = 9,
    parameter int DIVISOR = 13
) (
    input  logic [NUM_W-1:0] num,
    output logic [NUM_W-1:0] quo
);

    localparam int SHIFT_L = $clog2(DIVISOR);
    localparam int SHIFT   = NUM_W + SHIFT_L;
    localparam int MULT_W  = NUM_W + 2;
    localparam int PRODW   = NUM_W + MULT_W;
    localparam longint unsigned MULT_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_FULL);

    logic [PRODW-1:0] prod;

    // ceil(2^SHIFT / d) is exact for every NUM_W-bit numerator
    assign prod = PRODW'(num) * PRODW'(MULT);
    assign quo  = NUM_W'(prod >> SHIFT);

endmodule

>>> src/tbhu_addr_gen.sv
// Coordinate mapping: clamp, source row/column, fractions and frame store addresses.
module tbhu_addr_gen #(
    parameter int SRC_WIDTH           = tbhu_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT          = tbhu_pkg::SRC_HEIGHT_DEF,
    parameter int DST_WIDTH           = tbhu_pkg::DST_WIDTH_DEF,
    parameter int ROWS_PER_SOURCE_ROW = tbhu_pkg::ROWS_DEF,
    parameter int ADDR_W              = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         fire,
    input  logic                         cmd,
    input  logic [tbhu_pkg::WADDR_W-1:0] write_address,
    input  logic [tbhu_pkg::LEVEL_W-1:0] write_level,
    input  logic [tbhu_pkg::PIX_W-1:0]   pixel_x,
    input  logic [tbhu_pkg::PIX_W-1:0]   pixel_y,
    output logic                         c_pix,
    output tbhu_pkg::wr_req_t            wr,
    output tbhu_pkg::frac_t              frac,
    output logic [ADDR_W-1:0]            addr00,
    output logic [ADDR_W-1:0]            addr10,
    output logic [ADDR_W-1:0]            addr01,
    output logic [ADDR_W-1:0]            addr11
);

    localparam int PW      = tbhu_pkg::PIX_W;
    localparam int FW      = tbhu_pkg::FRAC_W;
    localparam int DEPTH   = SRC_WIDTH * SRC_HEIGHT;
    localparam int X_W     = $clog2(SRC_WIDTH);
    localparam int Y0_W    = $clog2(SRC_HEIGHT);
    localparam int PY_W    = (ROWS_PER_SOURCE_ROW > 1) ? $clog2(ROWS_PER_SOURCE_ROW) : 1;
    localparam int Y_LAST  = SRC_HEIGHT * ROWS_PER_SOURCE_ROW - 1;
    localparam int X_LAST  = DST_WIDTH - 1;
    localparam int TX_K    = (SRC_WIDTH - 1) * tbhu_pkg::FRAC_ONE;
    localparam int TX_W    = $clog2(TX_K + 1);
    localparam int TXQ     = TX_K / (DST_WIDTH - 1);
    localparam int TXR     = TX_K % (DST_WIDTH - 1);
    localparam int XC_MAX  = (X_LAST < tbhu_pkg::PIX_MAX) ? X_LAST : tbhu_pkg::PIX_MAX;
    localparam int XR_MAX  = XC_MAX * TXR;
    localparam int XR_W    = (XR_MAX > 0) ? $clog2(XR_MAX + 1) : 1;

    // Stage A
    logic                a_vld_reg;
    logic                a_px_reg;
    logic [tbhu_pkg::WADDR_W-1:0] a_waddr_reg;
    logic [tbhu_pkg::LEVEL_W-1:0] a_wlevel_reg;
    logic [PW-1:0]       a_yc_reg, a_yc_next;
    logic [Y0_W-1:0]     a_y0_reg, a_y0_next;
    logic [TX_W-1:0]     a_txa_reg, a_txa_next;
    logic [XR_W-1:0]     a_xr_reg, a_xr_next;
    logic [PW-1:0]       xc;
    logic [PW-1:0]       yq;

    // Stage B
    logic                b_vld_reg;
    logic                b_px_reg;
    logic [tbhu_pkg::WADDR_W-1:0] b_waddr_reg;
    logic [tbhu_pkg::LEVEL_W-1:0] b_wlevel_reg;
    logic [Y0_W-1:0]     b_y0_reg;
    logic [PY_W-1:0]     b_py_reg, b_py_next;
    logic [TX_W-1:0]     b_tx_reg, b_tx_next;
    logic [XR_W-1:0]     xq;

    // Stage C
    logic                c_vld_reg;
    logic                c_px_reg;
    logic                c_wen_reg, c_wen_next;
    logic [tbhu_pkg::WADDR_W-1:0] c_waddr_reg;
    logic [tbhu_pkg::LEVEL_W-1:0] c_wlevel_reg;
    logic [Y0_W-1:0]     c_y0_reg;
    logic [X_W-1:0]      c_x0_reg, c_x0_next;
    logic [FW-1:0]       c_fx_reg, c_fx_next;
    logic [FW-1:0]       c_fy_reg, c_fy_next;
    logic [PY_W+FW-1:0]  fyq;
    logic [X_W-1:0]      c_x1;
    logic [Y0_W-1:0]     c_y1;

    // Stage A: clamp, row = y / R, column product split as x*q + x*r/D
    always_comb
    begin
        if (32'(pixel_y) > Y_LAST) a_yc_next = PW'(Y_LAST);
        else                       a_yc_next = pixel_y;
        if (32'(pixel_x) > X_LAST) xc = PW'(X_LAST);
        else                       xc = pixel_x;
        a_y0_next  = Y0_W'(yq);
        a_txa_next = TX_W'(32'(xc) * TXQ);
        a_xr_next  = XR_W'(32'(xc) * TXR);
    end

    tbhu_cdiv #(.NUM_W(PW), .DIVISOR(ROWS_PER_SOURCE_ROW)) u_ydiv (
        .num (a_yc_next),
        .quo (yq)
    );

    // Stage B: remainder row and full column (unsigned 5.8 at the default sizes)
    tbhu_cdiv #(.NUM_W(XR_W), .DIVISOR(DST_WIDTH - 1)) u_xdiv (
        .num (a_xr_reg),
        .quo (xq)
    );

    always_comb
    begin
        b_py_next = PY_W'(32'(a_yc_reg) - 32'(a_y0_reg) * ROWS_PER_SOURCE_ROW);
        b_tx_next = a_txa_reg + TX_W'(xq);
    end

    // Stage C: fractions, left column, write qualification
    tbhu_cdiv #(.NUM_W(PY_W + FW), .DIVISOR(ROWS_PER_SOURCE_ROW)) u_fydiv (
        .num ({b_py_reg, {FW{1'b0}}}),
        .quo (fyq)
    );

    always_comb
    begin
        c_fy_next = FW'(fyq);
        c_fx_next = b_tx_reg[FW-1:0];
        if (32'(b_tx_reg >> FW) > SRC_WIDTH - 1) c_x0_next = X_W'(SRC_WIDTH - 1);
        else                                     c_x0_next = X_W'(b_tx_reg >> FW);
        c_wen_next = !b_px_reg && (32'(b_waddr_reg) < DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= fire;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_px_reg     <= (cmd == tbhu_pkg::CMD_PIXEL);
            a_waddr_reg  <= write_address;
            a_wlevel_reg <= write_level;
            a_yc_reg     <= a_yc_next;
            a_y0_reg     <= a_y0_next;
            a_txa_reg    <= a_txa_next;
            a_xr_reg     <= a_xr_next;

            b_px_reg     <= a_px_reg;
            b_waddr_reg  <= a_waddr_reg;
            b_wlevel_reg <= a_wlevel_reg;
            b_y0_reg     <= a_y0_reg;
            b_py_reg     <= b_py_next;
            b_tx_reg     <= b_tx_next;

            c_px_reg     <= b_px_reg;
            c_wen_reg    <= c_wen_next;
            c_waddr_reg  <= b_waddr_reg;
            c_wlevel_reg <= b_wlevel_reg;
            c_y0_reg     <= b_y0_reg;
            c_x0_reg     <= c_x0_next;
            c_fx_reg     <= c_fx_next;
            c_fy_reg     <= c_fy_next;
        end
    end

    // Neighbor indices, clamped at the last row and column
    always_comb
    begin
        if (32'(c_x0_reg) < SRC_WIDTH - 1)  c_x1 = c_x0_reg + 1'b1;
        else                                c_x1 = c_x0_reg;
        if (32'(c_y0_reg) < SRC_HEIGHT - 1) c_y1 = c_y0_reg + 1'b1;
        else                                c_y1 = c_y0_reg;
    end

    assign addr00 = ADDR_W'(32'(c_y0_reg) * SRC_WIDTH + 32'(c_x0_reg));
    assign addr10 = ADDR_W'(32'(c_y0_reg) * SRC_WIDTH + 32'(c_x1));
    assign addr01 = ADDR_W'(32'(c_y1) * SRC_WIDTH + 32'(c_x0_reg));
    assign addr11 = ADDR_W'(32'(c_y1) * SRC_WIDTH + 32'(c_x1));

    assign c_pix      = c_vld_reg && c_px_reg;
    assign wr.en      = c_vld_reg && c_wen_reg;
    assign wr.addr    = c_waddr_reg;
    assign wr.level   = c_wlevel_reg;
    assign frac.fx    = c_fx_reg;
    assign frac.fy    = c_fy_reg;

endmodule

>>> src/tbhu_frame_store.sv
// Frame store: two copies of the level memory, one per source row, each with two read ports.
module tbhu_frame_store #(
    parameter int DEPTH  = 768,
    parameter int ADDR_W = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  tbhu_pkg::wr_req_t            wr,
    input  logic [ADDR_W-1:0]            addr00,
    input  logic [ADDR_W-1:0]            addr10,
    input  logic [ADDR_W-1:0]            addr01,
    input  logic [ADDR_W-1:0]            addr11,
    output logic [tbhu_pkg::LEVEL_W-1:0] v00,
    output logic [tbhu_pkg::LEVEL_W-1:0] v10,
    output logic [tbhu_pkg::LEVEL_W-1:0] v01,
    output logic [tbhu_pkg::LEVEL_W-1:0] v11,
    output logic                         busy
);

    localparam int LW = tbhu_pkg::LEVEL_W;

    logic [LW-1:0]     row0_mem [DEPTH];
    logic [LW-1:0]     row1_mem [DEPTH];
    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [LW-1:0]     wd;

    // Clearing sweep after reset, one entry per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb
    begin
        we = clr_busy_reg || (adv && wr.en);
        wa = clr_busy_reg ? clr_cnt_reg : ADDR_W'(wr.addr);
        wd = clr_busy_reg ? '0 : wr.level;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row0_mem[wa] <= wd;
            row1_mem[wa] <= wd;
        end
        if (adv)
        begin
            v00 <= row0_mem[addr00];
            v10 <= row0_mem[addr10];
            v01 <= row1_mem[addr01];
            v11 <= row1_mem[addr11];
        end
    end

    assign busy = clr_busy_reg;

endmodule

>>> src/tbhu_blend.sv
// Bilinear blend: weights, four products, rounded sum and saturation.
module tbhu_blend (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         c_pix,
    input  tbhu_pkg::frac_t              frac,
    input  logic [tbhu_pkg::LEVEL_W-1:0] v00,
    input  logic [tbhu_pkg::LEVEL_W-1:0] v10,
    input  logic [tbhu_pkg::LEVEL_W-1:0] v01,
    input  logic [tbhu_pkg::LEVEL_W-1:0] v11,
    output logic                         f_vld,
    output logic [tbhu_pkg::LEVEL_W-1:0] lv
);

    localparam int FW = tbhu_pkg::FRAC_W;
    localparam int WW = tbhu_pkg::WEIGHT_W;
    localparam int PW = tbhu_pkg::PROD_W;
    localparam int SW = tbhu_pkg::SUM_W;
    localparam int LW = tbhu_pkg::LEVEL_W;

    logic [FW:0]   ifx, ify, fx9, fy9;
    logic          d_vld_reg, e_vld_reg, f_vld_reg;
    logic [WW-1:0] w00_reg, w10_reg, w01_reg, w11_reg;
    logic [WW-1:0] w00_next, w10_next, w01_next, w11_next;
    logic [PW-1:0] p00_reg, p10_reg, p01_reg, p11_reg;
    logic [PW-1:0] p00_next, p10_next, p01_next, p11_next;
    logic [SW-1:0] sum;
    logic [LW-1:0] lv_reg, lv_next;

    // Weights, registered alongside the store read
    always_comb
    begin
        fx9 = {1'b0, frac.fx};
        fy9 = {1'b0, frac.fy};
        ifx = (FW+1)'(tbhu_pkg::FRAC_ONE) - fx9;
        ify = (FW+1)'(tbhu_pkg::FRAC_ONE) - fy9;
        w00_next = WW'(ifx) * WW'(ify);
        w10_next = WW'(fx9) * WW'(ify);
        w01_next = WW'(ifx) * WW'(fy9);
        w11_next = WW'(fx9) * WW'(fy9);
    end

    always_comb
    begin
        p00_next = PW'(v00) * PW'(w00_reg);
        p10_next = PW'(v10) * PW'(w10_reg);
        p01_next = PW'(v01) * PW'(w01_reg);
        p11_next = PW'(v11) * PW'(w11_reg);
    end

    always_comb
    begin
        sum = SW'(p00_reg) + SW'(p10_reg) + SW'(p01_reg) + SW'(p11_reg)
            + SW'(tbhu_pkg::ROUND_HALF);
        if ((sum >> 16) > SW'(tbhu_pkg::LEVEL_MAX)) lv_next = LW'(tbhu_pkg::LEVEL_MAX);
        else                                        lv_next = sum[16 +: LW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= c_pix;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w00_reg <= w00_next;
            w10_reg <= w10_next;
            w01_reg <= w01_next;
            w11_reg <= w11_next;
            p00_reg <= p00_next;
            p10_reg <= p10_next;
            p01_reg <= p01_next;
            p11_reg <= p11_next;
            lv_reg  <= lv_next;
        end
    end

    assign f_vld = f_vld_reg;
    assign lv    = lv_reg;

endmodule

>>> src/thermal_bilinear_heatmap_upscaler_core.sv
// Top level of the thermal heat-map upscaler: pipeline, frame store and result buffer.
//
//  channel   handshake                    payload
//  -------   --------------------------   -----------------------------------------------
//  item      item_valid / item_ready      cmd, write_address, write_level, pixel_x, pixel_y
//  result    result_valid / result_ready  color, level
//
//  One beat per clock on either channel while neither side stalls. A pixel beat
//  passes stages A, B, C, the store read, the products and the sum to the output
//  register; a write beat passes stages A, B, C into the store, giving no result.
//  After reset the store is swept to zero, one entry a cycle over all entries
//  (SRC_WIDTH*SRC_HEIGHT, 768 by default), with item_ready low. Throughput is set
//  by the two dual-read store copies, one read per neighbor per cycle. A stalled
//  result parks in a skid register; the pipeline freezes only when it is full.
module thermal_bilinear_heatmap_upscaler_core #(
    parameter int SRC_WIDTH           = tbhu_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT          = tbhu_pkg::SRC_HEIGHT_DEF,
    parameter int DST_WIDTH           = tbhu_pkg::DST_WIDTH_DEF,
    parameter int ROWS_PER_SOURCE_ROW = tbhu_pkg::ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         cmd,
    input  logic [tbhu_pkg::WADDR_W-1:0] write_address,
    input  logic [tbhu_pkg::LEVEL_W-1:0] write_level,
    input  logic [tbhu_pkg::PIX_W-1:0]   pixel_x,
    input  logic [tbhu_pkg::PIX_W-1:0]   pixel_y,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [tbhu_pkg::COLOR_W-1:0] color,
    output logic [tbhu_pkg::LEVEL_W-1:0] level
);

    localparam int STORE_DEPTH = SRC_WIDTH * SRC_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LW          = tbhu_pkg::LEVEL_W;
    localparam int CW          = tbhu_pkg::COLOR_W;

    logic                adv;
    logic                fire;
    logic                clr_busy;
    logic                c_pix;
    tbhu_pkg::wr_req_t   wr;
    tbhu_pkg::frac_t     frac;
    logic [STORE_AW-1:0] addr00, addr10, addr01, addr11;
    logic [LW-1:0]       v00, v10, v01, v11;
    logic                f_vld;
    logic [LW-1:0]       f_lv;
    logic [CW-1:0]       f_color;
    logic                push, pop;

    // Output register plus skid register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_color_reg, out_color_next;
    logic [LW-1:0] out_level_reg, out_level_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [CW-1:0] skid_color_reg, skid_color_next;
    logic [LW-1:0] skid_level_reg, skid_level_next;

    // Whole pipeline moves together; it holds only while the skid slot is occupied
    assign adv        = !skid_valid_reg;
    assign item_ready = !skid_valid_reg && !clr_busy;
    assign fire       = item_valid && item_ready;

    tbhu_addr_gen #(
        .SRC_WIDTH           (SRC_WIDTH),
        .SRC_HEIGHT          (SRC_HEIGHT),
        .DST_WIDTH           (DST_WIDTH),
        .ROWS_PER_SOURCE_ROW (ROWS_PER_SOURCE_ROW),
        .ADDR_W              (STORE_AW)
    ) u_addr_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .fire          (fire),
        .cmd           (cmd),
        .write_address (write_address),
        .write_level   (write_level),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .c_pix         (c_pix),
        .wr            (wr),
        .frac          (frac),
        .addr00        (addr00),
        .addr10        (addr10),
        .addr01        (addr01),
        .addr11        (addr11)
    );

    // Writes and reads both happen at the stage C edge, so every pixel sees
    // exactly the writes taken before it and none after; no forwarding needed.
    tbhu_frame_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (STORE_AW)
    ) u_frame_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .wr     (wr),
        .addr00 (addr00),
        .addr10 (addr10),
        .addr01 (addr01),
        .addr11 (addr11),
        .v00    (v00),
        .v10    (v10),
        .v01    (v01),
        .v11    (v11),
        .busy   (clr_busy)
    );

    tbhu_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .c_pix (c_pix),
        .frac  (frac),
        .v00   (v00),
        .v10   (v10),
        .v01   (v01),
        .v11   (v11),
        .f_vld (f_vld),
        .lv    (f_lv)
    );

    // Color ramp lookup on the way into the output register
    assign f_color = tbhu_pkg::RAMP_LUT[{f_lv, 4'b0000} +: CW];

    assign push = f_vld && adv;
    assign pop  = out_valid_reg && result_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_color_next  = out_color_reg;
        out_level_next  = out_level_reg;
        skid_valid_next = skid_valid_reg;
        skid_color_next = skid_color_reg;
        skid_level_next = skid_level_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_color_next  = skid_color_reg;
                out_level_next  = skid_level_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_color_next = f_color;
                out_level_next = f_lv;
            end
        end
        else if (push)
        begin
            // output busy: park the beat
            skid_valid_next = 1'b1;
            skid_color_next = f_color;
            skid_level_next = f_lv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_color_reg  <= out_color_next;
        out_level_reg  <= out_level_next;
        skid_color_reg <= skid_color_next;
        skid_level_reg <= skid_level_next;
    end

    assign result_valid = out_valid_reg;
    assign color        = out_color_reg;
    assign level        = out_level_reg;

`ifndef SYNTHESIS
    // skid slot only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a new result beat must come from the pipeline tail
    a_out_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(push))
        else $error("result beat appeared without a pipeline result");

    // upper ramp segments run red at full scale
    a_ramp_red: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (32'(out_level_reg) >= tbhu_pkg::RAMP_K2))
        |-> (out_color_reg[15:11] == 5'h1F))
        else $error("red channel not saturated for a hot level");

    // lower ramp segments carry no green
    a_ramp_green: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (32'(out_level_reg) < tbhu_pkg::RAMP_K2))
        |-> (out_color_reg[10:5] == 6'd0))
        else $error("green channel set for a cool level");
`endif

endmodule
